[hw/rtl/mmbd_pkg.sv]
// Shared types and constants of the min/max bucket decimator.
// No dependencies; every other file of the block imports this package.
package mmbd_pkg;

    // Field and state widths
    localparam int SAMPLE_BITS  = 32;
    localparam int IDX_BITS     = 24;
    localparam int CNT_BITS     = 25;
    localparam int TGT_BITS     = 16;
    localparam int NB_BITS      = 15;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DAT_BITS = 25;

    // Series limits
    localparam logic [CNT_BITS-1:0] MAX_SAMPLES  = 25'd16777216;
    localparam logic [TGT_BITS-1:0] TARGET_RESET = 16'd1024;
    localparam logic [TGT_BITS-1:0] MIN_TARGET   = 16'd3;
    localparam logic [CNT_BITS-1:0] EDGE_SAMPLES = 25'd2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_POINTS = 8'd1;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // Divider steps, one quotient bit each
    localparam int DIV_STEPS = IDX_BITS;
    localparam int DIV_CNT_BITS = 5;

    typedef enum logic {
        CMD_EMIT   = 1'b0,   // pass value straight out, flag is series_end
        CMD_UPDATE = 1'b1    // fold into bucket min/max, flag closes the bucket
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                      kind;
        logic                           flag;
        logic [IDX_BITS-1:0]            index;
        logic signed [SAMPLE_BITS-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic                start;
        logic [IDX_BITS-1:0] dividend;
        logic [NB_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic [IDX_BITS-1:0] quot;
        logic [NB_BITS-1:0]  rem;
    } t_div_rsp;

endpackage

[hw/rtl/mmbd_ifs.sv]
// Handshake channel interfaces: sample input, result output, register writes.
// Depends on mmbd_pkg for field widths.
interface mmbd_smp_if import mmbd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mmbd_res_if import mmbd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          series_end;

    modport source (output valid, output value, output series_end, input ready);
    modport sink   (input valid, input value, input series_end, output ready);
endinterface

interface mmbd_cfg_if import mmbd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_DAT_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mmbd_div.sv]
// Restoring divider for the bucket boundary step, one quotient bit per cycle.
// Depends on mmbd_pkg.
module mmbd_div import mmbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [IDX_BITS-1:0]     r_quot;
    logic [NB_BITS-1:0]      r_rem;
    logic [NB_BITS-1:0]      r_dvs;

    logic [NB_BITS:0]        w_shift;
    logic                    w_ge;
    logic [NB_BITS:0]        w_diff;

    // one restoring step
    always_comb begin
        w_shift = {r_rem, r_quot[IDX_BITS-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= DIV_CNT_BITS'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[IDX_BITS-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[NB_BITS-1:0] : w_shift[NB_BITS-1:0];
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

[hw/rtl/mmbd_front.sv]
// Front end: register file, sample index and bucket boundary tracking.
// Classifies each sample into a command for the back end. Depends on mmbd_pkg.
module mmbd_front import mmbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mmbd_cfg_if.sink i_cfg,
    mmbd_smp_if.sink i_smp,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    output logic     o_push,
    output t_cmd     o_cmd,
    input  logic     i_full
);

    logic [CNT_BITS-1:0] r_sample_count;
    logic [TGT_BITS-1:0] r_target_points;
    logic                r_div_start;
    logic [IDX_BITS-1:0] r_idx;
    logic [CNT_BITS-1:0] r_end;
    logic [NB_BITS-1:0]  r_brem;

    logic [IDX_BITS-1:0] n_idx;
    logic [CNT_BITS-1:0] n_end;
    logic [NB_BITS-1:0]  n_brem;

    logic [CNT_BITS-1:0] w_n;
    logic [TGT_BITS-1:0] w_tm2;
    logic [NB_BITS-1:0]  w_nb;
    logic                w_decim;
    logic [CNT_BITS-1:0] w_idx_p1;
    logic                w_last;
    logic                w_close;
    logic [NB_BITS:0]    w_rem_sum;
    logic [CNT_BITS-1:0] w_end_sum;
    logic [CNT_BITS-1:0] w_nm2;
    logic                w_accept;
    logic                w_cfg_hit;

    // effective count, bucket count and mode
    always_comb begin
        w_n     = (r_sample_count > MAX_SAMPLES) ? MAX_SAMPLES : r_sample_count;
        w_tm2   = r_target_points - 16'd2;
        w_nb    = (w_tm2[TGT_BITS-1:1] == '0) ? NB_BITS'(1) : w_tm2[TGT_BITS-1:1];
        w_decim = (w_n > {{(CNT_BITS-TGT_BITS){1'b0}}, r_target_points})
                  && (r_target_points >= MIN_TARGET);
        w_nm2   = w_n - EDGE_SAMPLES;
    end

    assign i_smp.ready = !r_div_start && !i_div_rsp.busy && !i_full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_cfg_hit   = i_cfg.valid && i_cfg.ready
                         && (i_cfg.index == REG_SAMPLE_COUNT
                             || i_cfg.index == REG_TARGET_POINTS);

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = w_nm2[IDX_BITS-1:0];
    assign o_div_req.divisor  = w_nb;

    // sample classification
    always_comb begin
        w_idx_p1  = {1'b0, r_idx} + 1'b1;
        w_last    = (w_idx_p1 >= w_n);
        w_close   = ({1'b0, r_idx} == r_end);
        w_rem_sum = {1'b0, r_brem} + {1'b0, i_div_rsp.rem};
        w_end_sum = r_end + {1'b0, i_div_rsp.quot};
        if (w_rem_sum >= {1'b0, w_nb}) begin
            w_rem_sum = w_rem_sum - {1'b0, w_nb};
            w_end_sum = w_end_sum + 1'b1;
        end

        o_push      = 1'b0;
        o_cmd.kind  = CMD_EMIT;
        o_cmd.flag  = 1'b0;
        o_cmd.index = r_idx;
        o_cmd.value = i_smp.sample;
        n_idx       = r_idx;
        n_end       = r_end;
        n_brem      = r_brem;

        if (w_accept && w_n != '0) begin
            o_push = 1'b1;
            if (!w_decim) begin
                // pass-through series
                o_cmd.flag = w_last;
                n_idx      = w_last ? '0 : w_idx_p1[IDX_BITS-1:0];
            end else if (r_idx == '0) begin
                // first sample of a decimated series
                n_end  = {1'b0, i_div_rsp.quot};
                n_brem = i_div_rsp.rem;
                n_idx  = IDX_BITS'(1);
            end else if (w_last) begin
                // closing sample of the series
                o_cmd.flag = 1'b1;
                n_idx      = '0;
                n_end      = '0;
                n_brem     = '0;
            end else begin
                // inner sample, possibly ending its bucket
                o_cmd.kind = CMD_UPDATE;
                o_cmd.flag = w_close;
                n_idx      = w_idx_p1[IDX_BITS-1:0];
                if (w_close) begin
                    n_end  = w_end_sum;
                    n_brem = w_rem_sum[NB_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count  <= '0;
            r_target_points <= TARGET_RESET;
            r_div_start     <= 1'b1;
            r_idx           <= '0;
            r_end           <= '0;
            r_brem          <= '0;
        end else if (w_cfg_hit) begin
            // register write restarts the series and reruns the divider
            if (i_cfg.index == REG_SAMPLE_COUNT) begin
                r_sample_count <= i_cfg.data[CNT_BITS-1:0];
            end else begin
                r_target_points <= i_cfg.data[TGT_BITS-1:0];
            end
            r_div_start <= 1'b1;
            r_idx       <= '0;
            r_end       <= '0;
            r_brem      <= '0;
        end else begin
            r_div_start <= 1'b0;
            r_idx       <= n_idx;
            r_end       <= n_end;
            r_brem      <= n_brem;
        end
    end

endmodule

[hw/rtl/mmbd_queue.sv]
// Short command queue between the front and back ends.
// Depends on mmbd_pkg.
module mmbd_queue import mmbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

[hw/rtl/mmbd_back.sv]
// Back end: bucket min/max tracking and result emission with an output register.
// Depends on mmbd_pkg and the result interface.
module mmbd_back import mmbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    mmbd_res_if.source o_res
);

    logic                          r_open;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic signed [SAMPLE_BITS-1:0] r_hi;
    logic [IDX_BITS-1:0]           r_lo_pos;
    logic [IDX_BITS-1:0]           r_hi_pos;
    logic                          r_pend;
    logic signed [SAMPLE_BITS-1:0] r_pend_value;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_end;

    logic signed [SAMPLE_BITS-1:0] n_lo;
    logic signed [SAMPLE_BITS-1:0] n_hi;
    logic [IDX_BITS-1:0]           n_lo_pos;
    logic [IDX_BITS-1:0]           n_hi_pos;
    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_lo_first;

    // fold the head sample into the running extremes
    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_lo_pos = r_lo_pos;
        n_hi_pos = r_hi_pos;
        if (!r_open) begin
            n_lo     = i_cmd.value;
            n_hi     = i_cmd.value;
            n_lo_pos = i_cmd.index;
            n_hi_pos = i_cmd.index;
        end else begin
            if (i_cmd.value < r_lo) begin
                n_lo     = i_cmd.value;
                n_lo_pos = i_cmd.index;
            end
            if (i_cmd.value > r_hi) begin
                n_hi     = i_cmd.value;
                n_hi_pos = i_cmd.index;
            end
        end
        w_lo_first = (n_lo_pos <= n_hi_pos);
    end

    assign w_out_free = !r_out_valid || o_res.ready;
    assign o_pop = i_valid && !r_pend
                   && (w_out_free || (i_cmd.kind == CMD_UPDATE && !i_cmd.flag));
    // output register takes a new result
    assign w_out_load = (r_pend && w_out_free)
                        || (o_pop && (i_cmd.kind == CMD_EMIT || i_cmd.flag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_pend && w_out_free) begin
                // second value of a closed bucket
                r_out_value <= r_pend_value;
                r_out_end   <= 1'b0;
                r_pend      <= 1'b0;
            end else if (o_pop) begin
                unique case (i_cmd.kind)
                    CMD_EMIT: begin
                        r_out_value <= i_cmd.value;
                        r_out_end   <= i_cmd.flag;
                        r_open      <= 1'b0;
                    end
                    CMD_UPDATE: begin
                        r_lo     <= n_lo;
                        r_hi     <= n_hi;
                        r_lo_pos <= n_lo_pos;
                        r_hi_pos <= n_hi_pos;
                        if (i_cmd.flag) begin
                            // bucket ends: extremes in index order
                            r_out_value  <= w_lo_first ? n_lo : n_hi;
                            r_out_end    <= 1'b0;
                            r_pend       <= (n_lo_pos != n_hi_pos);
                            r_pend_value <= w_lo_first ? n_hi : n_lo;
                            r_open       <= 1'b0;
                        end else begin
                            r_open <= 1'b1;
                        end
                    end
                    default: begin
                        r_open <= r_open;
                    end
                endcase
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_out_value;
    assign o_res.series_end = r_out_end;

endmodule

[hw/rtl/minmax_bucket_decimator.sv]
// Top level of the min/max bucket decimator: front end, divider, queue, back end.
// Depends on mmbd_pkg, the channel interfaces and all mmbd_* modules.
//
// Samples stream in on i_smp and the decimated series leaves on o_res. Once
// running, a sample is taken every cycle unless the queue is full; a closing
// bucket yields one or two results, sent one per cycle from the output register
// while o_res is ready, and a four-entry command queue between the classifying
// front end and the min/max back end absorbs those bursts and output stalls.
// After reset and after every write to sample_count or target_points, the bucket
// size is found by a one-bit-per-cycle divider; samples wait while its start is
// registered and its quotient steps run. A register write restarts the series;
// writes to other indexes are dropped. The configuration port is always ready.
module minmax_bucket_decimator import mmbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmbd_cfg_if.sink   i_cfg,
    mmbd_smp_if.sink   i_smp,
    mmbd_res_if.source o_res
);

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic     w_push;
    t_cmd     w_push_cmd;
    logic     w_full;
    logic     w_q_valid;
    t_cmd     w_q_cmd;
    logic     w_pop;

    mmbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_smp     (i_smp),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_full    (w_full)
    );

    mmbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    mmbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    mmbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

[hw/rtl/mmbd_checker.sv]
// Port-level assertions for the min/max bucket decimator, bound to the top level.
// Depends on mmbd_pkg and minmax_bucket_decimator.
module mmbd_checker import mmbd_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          i_cfg_ready,
    input logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input logic                          i_smp_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic signed [SAMPLE_BITS-1:0] i_res_value,
    input logic                          i_res_series_end
);

    // a stalled result holds its value
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_value) && $stable(i_res_series_end))
        else $error("result changed while stalled");

    // a register write starts the divider, so samples are held off next cycle
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready
            && (i_cfg_index == REG_SAMPLE_COUNT || i_cfg_index == REG_TARGET_POINTS)
        |=> !i_smp_ready)
        else $error("sample accepted before bucket division restarted");

    // reset empties the output and holds off samples
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && !i_smp_ready)
        else $error("output or sample ready active right after reset");

endmodule

bind minmax_bucket_decimator mmbd_checker u_mmbd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_valid      (i_cfg.valid),
    .i_cfg_ready      (i_cfg.ready),
    .i_cfg_index      (i_cfg.index),
    .i_smp_ready      (i_smp.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_value      (o_res.value),
    .i_res_series_end (o_res.series_end)
);

[tb/tb_minmax_bucket_decimator.sv]
`timescale 1ns / 100ps
// Self-checking testbench for minmax_bucket_decimator: directed and random series
// checked against an in-bench min/max bucket predictor. Depends on mmbd_pkg, the
// channel interfaces in mmbd_ifs.sv and the block's RTL.
module tb_minmax_bucket_decimator;
    import mmbd_pkg::*;

    localparam int SETTLE_CYCLES = 40;     // divider restart plus queue flush
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 200;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample value;
        logic    series_end;
    } t_point;

    logic i_clk;
    logic i_rst_n;

    mmbd_cfg_if cfg_ch ();
    mmbd_smp_if smp_ch ();
    mmbd_res_if res_ch ();

    minmax_bucket_decimator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_smp   (smp_ch),
        .o_res   (res_ch)
    );

    // Predictor state: registers and series progress
    logic [CNT_BITS-1:0] series_len;
    logic [TGT_BITS-1:0] want_points;
    longint unsigned     pos;
    longint unsigned     bucket_last;
    longint unsigned     bucket_rem;
    longint unsigned     lo_at;
    longint unsigned     hi_at;
    t_sample             lo_val;
    t_sample             hi_val;

    t_point pending_points[$];
    int     mismatches;
    int     quiet_cycles;

    // Stimulus shaping
    int      burst_left;
    bit      gaps_on;
    bit      stall_on;
    bit      hold_start;
    int      hold_left;
    int      stall_run;
    t_sample prev_sample;

    // Clock, 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void restart_series();
        pos = 0;
        bucket_last = 0;
        bucket_rem = 0;
        lo_at = 0;
        hi_at = 0;
        lo_val = '0;
        hi_val = '0;
    endfunction

    function automatic void queue_point(input t_sample v, input logic last);
        t_point p;
        p.value = v;
        p.series_end = last;
        pending_points.insert(pending_points.size(), p);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DAT_BITS-1:0] dat);
        case (idx)
            REG_SAMPLE_COUNT: begin
                series_len = dat[CNT_BITS-1:0];
                restart_series();
            end
            REG_TARGET_POINTS: begin
                want_points = dat[TGT_BITS-1:0];
                restart_series();
            end
            default: ;  // unknown index: dropped, series keeps going
        endcase
    endfunction

    // Expected output points for one accepted sample
    function automatic void decimate_sample(input t_sample s);
        longint unsigned n, t, nb, q, r, rem, e;
        logic last;
        n = series_len;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        t = want_points;
        if (n == 0)
            return;
        // pass-through: short series or too few target points
        if (n <= t || t < MIN_TARGET) begin
            last = (pos + 1 >= n);
            queue_point(s, last);
            pos = last ? 0 : pos + 1;
            return;
        end
        nb = (t - 2) / 2;
        if (nb < 1)
            nb = 1;
        q = (n - 2) / nb;
        r = (n - 2) % nb;
        // first sample always goes out
        if (pos == 0) begin
            queue_point(s, 1'b0);
            bucket_last = q;
            bucket_rem = r;
            lo_at = 0;
            hi_at = 0;
            pos = 1;
            return;
        end
        // last sample closes the series
        if (pos + 1 >= n) begin
            queue_point(s, 1'b1);
            restart_series();
            return;
        end
        // track first-occurring extremes of the bucket
        if (lo_at == 0) begin
            lo_val = s;
            hi_val = s;
            lo_at = pos;
            hi_at = pos;
        end else begin
            if (s < lo_val) begin
                lo_val = s;
                lo_at = pos;
            end
            if (s > hi_val) begin
                hi_val = s;
                hi_at = pos;
            end
        end
        // bucket closes: extremes out in index order
        if (pos == bucket_last) begin
            if (lo_at <= hi_at) begin
                queue_point(lo_val, 1'b0);
                if (hi_at != lo_at)
                    queue_point(hi_val, 1'b0);
            end else begin
                queue_point(hi_val, 1'b0);
                queue_point(lo_val, 1'b0);
            end
            lo_at = 0;
            hi_at = 0;
            rem = bucket_rem + r;
            e = bucket_last + q;
            if (rem >= nb) begin
                rem -= nb;
                e += 1;
            end
            bucket_rem = rem;
            bucket_last = e;
        end
        pos = pos + 1;
    endfunction

    // Mix of full-range, small, extreme, repeated and nearby values
    function automatic t_sample random_sample();
        t_sample s;
        case ($urandom_range(0, 5)) inside
            0, 1: s = $urandom;
            2: s = t_sample'($urandom_range(0, 15)) - 8;
            3: begin
                case ($urandom_range(0, 3))
                    0: s = 32'sh7FFF_FFFF;
                    1: s = 32'sh8000_0000;
                    2: s = '0;
                    default: s = -1;
                endcase
            end
            4: s = prev_sample;
            default: s = prev_sample + t_sample'($urandom_range(0, 6)) - 3;
        endcase
        prev_sample = s;
        return s;
    endfunction

    // One sample transaction, sender in bursts with random gaps
    task automatic send_sample(input t_sample s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                smp_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        smp_ch.valid <= 1'b1;
        smp_ch.sample <= s;
        @(posedge i_clk);
        while (!smp_ch.ready)
            @(posedge i_clk);
        decimate_sample(s);
        @(negedge i_clk);
    endtask

    // Stop offering samples, wait for every expected point, then let the block settle
    task automatic drain_results(input int settle);
        smp_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] dat);
        drain_results(SETTLE_CYCLES);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= dat;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        apply_reg(idx, dat);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset state: sample_count 0, every sample dropped
    task automatic test_empty_series();
        send_sample(32'sh1234_5678);
        send_sample(32'sh8000_0000);
    endtask

    // Short series with default target passes through unchanged
    task automatic test_passthrough();
        write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(4));
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0000_0000);
        send_sample(-32'sd1);
    endtask

    // Target below the decimation minimum forces pass-through
    task automatic test_short_target();
        write_reg(REG_TARGET_POINTS, CFG_DAT_BITS'(0));
        write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(2));
        send_sample(32'sh0001_0000);
        send_sample(32'shFFFF_0000);
    endtask

    // Single bucket: max before min, then a flat bucket with one point
    task automatic test_bucket_order();
        write_reg(REG_TARGET_POINTS, CFG_DAT_BITS'(3));
        write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(5));
        send_sample(32'sh0000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh0000_0004);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0000_0001);
        write_reg(REG_TARGET_POINTS, CFG_DAT_BITS'(4));
        repeat (5) send_sample(32'sh0007_0000);
    endtask

    // Uneven buckets; a write to an unknown index mid-series changes nothing
    task automatic test_multi_bucket();
        write_reg(REG_TARGET_POINTS, CFG_DAT_BITS'(6));
        write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(9));
        send_sample(32'sd1);
        send_sample(-32'sd5);
        send_sample(32'sd20);
        send_sample(32'sd20);
        write_reg(CFG_IDX_BITS'(2), CFG_DAT_BITS'(3));
        send_sample(-32'sd5);
        send_sample(32'sd7);
        send_sample(32'sd30);
        send_sample(-32'sd30);
        write_reg(CFG_IDX_BITS'(8'hFF), '1);
        send_sample(32'sd2);
    endtask

    // Largest target and counts at and above the series limit; writes restart mid-series
    task automatic test_count_limits();
        write_reg(REG_TARGET_POINTS, '1);
        write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(MAX_SAMPLES));
        send_sample(32'sh5555_5555);
        send_sample(32'shAAAA_AAAA);
        write_reg(REG_SAMPLE_COUNT, '1);
        send_sample(32'sh0F0F_0F0F);
    endtask

    // Receiver holds off while the sender keeps offering: queue fills, input stalls
    task automatic test_backpressure();
        write_reg(REG_TARGET_POINTS, CFG_DAT_BITS'(1024));
        write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(64));
        gaps_on = 1'b0;
        stall_on = 1'b0;
        hold_start = 1'b1;
        repeat (64) send_sample(random_sample());
    endtask

    // Random series: mostly decimating, some pass-through, short targets, cut series
    task automatic test_random_series();
        int unsigned len, pts, cut, reps, kind, done;
        logic [CFG_DAT_BITS-1:0] pts_word;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                len = $urandom_range(4, 40);
                pts = $urandom_range(3, len - 1);
            end else if (kind < 80) begin
                len = $urandom_range(1, 24);
                pts = $urandom_range(len, 300);
            end else if (kind < 92) begin
                len = $urandom_range(1, 24);
                pts = $urandom_range(0, 2);
            end else if (kind < 97) begin
                len = $urandom_range(60, 160);
                pts = $urandom_range(3, 24);
            end else begin
                len = 0;
                pts = $urandom_range(0, 100);
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            pts_word = CFG_DAT_BITS'(pts);
            if ($urandom_range(0, 3) == 0)
                pts_word[CFG_DAT_BITS-1:TGT_BITS] = (CFG_DAT_BITS-TGT_BITS)'($urandom);
            if ($urandom_range(0, 1)) begin
                write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(len));
                write_reg(REG_TARGET_POINTS, pts_word);
            end else begin
                write_reg(REG_TARGET_POINTS, pts_word);
                write_reg(REG_SAMPLE_COUNT, CFG_DAT_BITS'(len));
            end
            reps = $urandom_range(1, 2);
            repeat (reps) begin
                if (len == 0)
                    cut = $urandom_range(1, 4);
                else if ($urandom_range(0, 9) == 0)
                    cut = $urandom_range(1, len);
                else
                    cut = len;
                for (int k = 0; k < cut; k++)
                    send_sample(random_sample());
                if (len != 0)
                    done += cut;
            end
        end
    endtask

    // Receiver: long hold-off on request, otherwise short random stall runs
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_left = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
            res_ch.ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            stall_run = $urandom_range(0, 4);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expected point
    always @(posedge i_clk) begin : check_results
        t_point want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point: expected none, actual value %h end %b",
                         $time, res_ch.value, res_ch.series_end);
                mismatches++;
            end else begin
                want = pending_points.pop_front();
                if (res_ch.value !== want.value) begin
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.value, res_ch.value);
                    mismatches++;
                end
                if (res_ch.series_end !== want.series_end) begin
                    $display("%0t: series_end mismatch: expected %b, actual %b",
                             $time, want.series_end, res_ch.series_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d points still expected", $time, pending_points.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        stall_on = 1'b1;
        hold_start = 1'b0;
        hold_left = 0;
        stall_run = 0;
        prev_sample = '0;
        series_len = '0;
        want_points = TARGET_RESET;
        restart_series();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_series();
        test_passthrough();
        test_short_target();
        test_bucket_order();
        test_multi_bucket();
        test_count_limits();
        test_backpressure();
        test_random_series();

        drain_results(DRAIN_CYCLES);
        if (pending_points.size() != 0) begin
            $display("%0t: %0d expected points never arrived", $time, pending_points.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
